[design/obbot_pkg.sv]
// Shared constants for the oriented-box overlap unit.
`default_nettype none

package obbot_pkg;

  localparam int unsigned COORD_WIDTH_DEF    = 16;
  localparam int unsigned AXIS_FRAC_BITS_DEF = 14;

  // Register stages from an accepted item to its result strobe.
  localparam int unsigned LATENCY = 5;

  // Test axes, in the order the separation results are indexed.
  localparam int unsigned NUM_AXES = 4;
  localparam int unsigned AXIS_UA  = 0;
  localparam int unsigned AXIS_VA  = 1;
  localparam int unsigned AXIS_UB  = 2;
  localparam int unsigned AXIS_VB  = 3;

endpackage

`default_nettype wire

[design/obbot_proj.sv]
// Projection stages: axis and distance products, then dot sums, floor and magnitude.
`default_nettype none

module obbot_proj #(
  parameter int unsigned COORD_WIDTH    = obbot_pkg::COORD_WIDTH_DEF,
  parameter int unsigned AXIS_FRAC_BITS = obbot_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  input  logic signed [AXIS_FRAC_BITS+1:0]             a_axis_x_i,
  input  logic signed [AXIS_FRAC_BITS+1:0]             a_axis_y_i,
  input  logic signed [AXIS_FRAC_BITS+1:0]             b_axis_x_i,
  input  logic signed [AXIS_FRAC_BITS+1:0]             b_axis_y_i,
  input  logic signed [COORD_WIDTH:0]                  dx_i,
  input  logic signed [COORD_WIDTH:0]                  dy_i,
  input  logic        [COORD_WIDTH-2:0]                a_half_width_i,
  input  logic        [COORD_WIDTH-2:0]                a_half_height_i,
  input  logic        [COORD_WIDTH-2:0]                b_half_width_i,
  input  logic        [COORD_WIDTH-2:0]                b_half_height_i,
  output logic                                         valid_o,
  output logic        [AXIS_FRAC_BITS+4:0]             fna_o,
  output logic        [AXIS_FRAC_BITS+4:0]             fnb_o,
  output logic        [AXIS_FRAC_BITS+4:0]             fc_o,
  output logic        [AXIS_FRAC_BITS+4:0]             fs_o,
  output logic        [AXIS_FRAC_BITS+4:0]             fsn_o,
  output logic        [COORD_WIDTH+AXIS_FRAC_BITS+3:0] dist_o [obbot_pkg::NUM_AXES],
  output logic        [COORD_WIDTH-2:0]                a_half_width_o,
  output logic        [COORD_WIDTH-2:0]                a_half_height_o,
  output logic        [COORD_WIDTH-2:0]                b_half_width_o,
  output logic        [COORD_WIDTH-2:0]                b_half_height_o
);

  localparam int unsigned AW  = AXIS_FRAC_BITS + 2;
  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned PA  = 2 * AW;
  localparam int unsigned PD  = DW + AW;
  localparam int unsigned FW  = PA + 1 - AXIS_FRAC_BITS;
  localparam int unsigned HW  = COORD_WIDTH - 1;

  // Stage 2: products
  logic               v2_q;
  logic signed [PA-1:0] p_axax_q, p_ayay_q, p_bxbx_q, p_byby_q;
  logic signed [PA-1:0] p_axbx_q, p_ayby_q, p_aybx_q, p_axby_q;
  logic signed [PD-1:0] p_dxax_q, p_dyay_q, p_dxay_q, p_dyax_q;
  logic signed [PD-1:0] p_dxbx_q, p_dyby_q, p_dxby_q, p_dybx_q;
  logic [HW-1:0]        hwa2_q, hha2_q, hwb2_q, hhb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_axax_q <= a_axis_x_i * a_axis_x_i;
    p_ayay_q <= a_axis_y_i * a_axis_y_i;
    p_bxbx_q <= b_axis_x_i * b_axis_x_i;
    p_byby_q <= b_axis_y_i * b_axis_y_i;
    p_axbx_q <= a_axis_x_i * b_axis_x_i;
    p_ayby_q <= a_axis_y_i * b_axis_y_i;
    p_aybx_q <= a_axis_y_i * b_axis_x_i;
    p_axby_q <= a_axis_x_i * b_axis_y_i;
    p_dxax_q <= dx_i * a_axis_x_i;
    p_dyay_q <= dy_i * a_axis_y_i;
    p_dxay_q <= dx_i * a_axis_y_i;
    p_dyax_q <= dy_i * a_axis_x_i;
    p_dxbx_q <= dx_i * b_axis_x_i;
    p_dyby_q <= dy_i * b_axis_y_i;
    p_dxby_q <= dx_i * b_axis_y_i;
    p_dybx_q <= dy_i * b_axis_x_i;
    hwa2_q   <= a_half_width_i;
    hha2_q   <= a_half_height_i;
    hwb2_q   <= b_half_width_i;
    hhb2_q   <= b_half_height_i;
  end

  // Stage 3: dot sums, floor to integer units, magnitudes
  logic [PA:0] na, nb, c, s, sn;
  logic [PD:0] du_a, dv_a, du_b, dv_b;
  logic [FW-1:0] fc, fs, fsn;

  always_comb begin
    na   = {p_axax_q[PA-1], p_axax_q} + {p_ayay_q[PA-1], p_ayay_q};
    nb   = {p_bxbx_q[PA-1], p_bxbx_q} + {p_byby_q[PA-1], p_byby_q};
    c    = {p_axbx_q[PA-1], p_axbx_q} + {p_ayby_q[PA-1], p_ayby_q};
    s    = {p_aybx_q[PA-1], p_aybx_q} - {p_axby_q[PA-1], p_axby_q};
    sn   = {p_axby_q[PA-1], p_axby_q} - {p_aybx_q[PA-1], p_aybx_q};
    du_a = {p_dxax_q[PD-1], p_dxax_q} + {p_dyay_q[PD-1], p_dyay_q};
    dv_a = {p_dyax_q[PD-1], p_dyax_q} - {p_dxay_q[PD-1], p_dxay_q};
    du_b = {p_dxbx_q[PD-1], p_dxbx_q} + {p_dyby_q[PD-1], p_dyby_q};
    dv_b = {p_dybx_q[PD-1], p_dybx_q} - {p_dxby_q[PD-1], p_dxby_q};
    // arithmetic shift keeps the upper bits; take magnitude of the floored value
    fc  = c[PA]  ? (~c[PA:AXIS_FRAC_BITS] + 1'b1)  : c[PA:AXIS_FRAC_BITS];
    fs  = s[PA]  ? (~s[PA:AXIS_FRAC_BITS] + 1'b1)  : s[PA:AXIS_FRAC_BITS];
    fsn = sn[PA] ? (~sn[PA:AXIS_FRAC_BITS] + 1'b1) : sn[PA:AXIS_FRAC_BITS];
  end

  logic          v3_q;
  logic [FW-1:0] fna_q, fnb_q, fc_q, fs_q, fsn_q;
  logic [PD:0]   dist_q [obbot_pkg::NUM_AXES];
  logic [HW-1:0] hwa3_q, hha3_q, hwb3_q, hhb3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // squared norms are never negative
    fna_q <= na[PA:AXIS_FRAC_BITS];
    fnb_q <= nb[PA:AXIS_FRAC_BITS];
    fc_q  <= fc;
    fs_q  <= fs;
    fsn_q <= fsn;
    dist_q[obbot_pkg::AXIS_UA] <= du_a[PD] ? (~du_a + 1'b1) : du_a;
    dist_q[obbot_pkg::AXIS_VA] <= dv_a[PD] ? (~dv_a + 1'b1) : dv_a;
    dist_q[obbot_pkg::AXIS_UB] <= du_b[PD] ? (~du_b + 1'b1) : du_b;
    dist_q[obbot_pkg::AXIS_VB] <= dv_b[PD] ? (~dv_b + 1'b1) : dv_b;
    hwa3_q <= hwa2_q;
    hha3_q <= hha2_q;
    hwb3_q <= hwb2_q;
    hhb3_q <= hhb2_q;
  end

  assign valid_o         = v3_q;
  assign fna_o           = fna_q;
  assign fnb_o           = fnb_q;
  assign fc_o            = fc_q;
  assign fs_o            = fs_q;
  assign fsn_o           = fsn_q;
  assign dist_o          = dist_q;
  assign a_half_width_o  = hwa3_q;
  assign a_half_height_o = hha3_q;
  assign b_half_width_o  = hwb3_q;
  assign b_half_height_o = hhb3_q;

endmodule

`default_nettype wire

[design/obbot_sep.sv]
// Separation stages: projection radii products, radius sums and compare per axis.
`default_nettype none

module obbot_sep #(
  parameter int unsigned COORD_WIDTH    = obbot_pkg::COORD_WIDTH_DEF,
  parameter int unsigned AXIS_FRAC_BITS = obbot_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic [AXIS_FRAC_BITS+4:0]             fna_i,
  input  logic [AXIS_FRAC_BITS+4:0]             fnb_i,
  input  logic [AXIS_FRAC_BITS+4:0]             fc_i,
  input  logic [AXIS_FRAC_BITS+4:0]             fs_i,
  input  logic [AXIS_FRAC_BITS+4:0]             fsn_i,
  input  logic [COORD_WIDTH+AXIS_FRAC_BITS+3:0] dist_i [obbot_pkg::NUM_AXES],
  input  logic [COORD_WIDTH-2:0]                a_half_width_i,
  input  logic [COORD_WIDTH-2:0]                a_half_height_i,
  input  logic [COORD_WIDTH-2:0]                b_half_width_i,
  input  logic [COORD_WIDTH-2:0]                b_half_height_i,
  output logic                                  valid_o,
  output logic                                  overlap_o
);

  localparam int unsigned FW  = AXIS_FRAC_BITS + 5;
  localparam int unsigned HW  = COORD_WIDTH - 1;
  localparam int unsigned RW  = HW + FW;
  localparam int unsigned SW  = RW + 2;
  localparam int unsigned DSW = COORD_WIDTH + AXIS_FRAC_BITS + 4;

  localparam int unsigned UA = obbot_pkg::AXIS_UA;
  localparam int unsigned VA = obbot_pkg::AXIS_VA;
  localparam int unsigned UB = obbot_pkg::AXIS_UB;
  localparam int unsigned VB = obbot_pkg::AXIS_VB;

  logic [RW-1:0] hwa, hha, hwb, hhb;
  logic [RW-1:0] fna, fnb, fc, fs, fsn;

  always_comb begin
    hwa = {{FW{1'b0}}, a_half_width_i};
    hha = {{FW{1'b0}}, a_half_height_i};
    hwb = {{FW{1'b0}}, b_half_width_i};
    hhb = {{FW{1'b0}}, b_half_height_i};
    fna = {{HW{1'b0}}, fna_i};
    fnb = {{HW{1'b0}}, fnb_i};
    fc  = {{HW{1'b0}}, fc_i};
    fs  = {{HW{1'b0}}, fs_i};
    fsn = {{HW{1'b0}}, fsn_i};
  end

  // Stage 4: extent times projected axis, three terms per test axis
  logic          v4_q;
  logic [RW-1:0] rp_q [obbot_pkg::NUM_AXES][3];
  logic [DSW-1:0] dist4_q [obbot_pkg::NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q[UA][0] <= hwa * fna;
    rp_q[UA][1] <= hwb * fc;
    rp_q[UA][2] <= hhb * fs;
    rp_q[VA][0] <= hha * fna;
    rp_q[VA][1] <= hwb * fsn;
    rp_q[VA][2] <= hhb * fc;
    rp_q[UB][0] <= hwa * fc;
    rp_q[UB][1] <= hha * fsn;
    rp_q[UB][2] <= hwb * fnb;
    rp_q[VB][0] <= hwa * fs;
    rp_q[VB][1] <= hha * fc;
    rp_q[VB][2] <= hhb * fnb;
    dist4_q     <= dist_i;
  end

  // Stage 5: touching counts as separated
  logic [SW-1:0] rsum_ua, rsum_va, rsum_ub, rsum_vb;
  logic          sep_ua, sep_va, sep_ub, sep_vb;

  always_comb begin
    rsum_ua = {2'b00, rp_q[UA][0]} + {2'b00, rp_q[UA][1]} + {2'b00, rp_q[UA][2]};
    rsum_va = {2'b00, rp_q[VA][0]} + {2'b00, rp_q[VA][1]} + {2'b00, rp_q[VA][2]};
    rsum_ub = {2'b00, rp_q[UB][0]} + {2'b00, rp_q[UB][1]} + {2'b00, rp_q[UB][2]};
    rsum_vb = {2'b00, rp_q[VB][0]} + {2'b00, rp_q[VB][1]} + {2'b00, rp_q[VB][2]};
    sep_ua  = rsum_ua <= {{(SW-DSW){1'b0}}, dist4_q[UA]};
    sep_va  = rsum_va <= {{(SW-DSW){1'b0}}, dist4_q[VA]};
    sep_ub  = rsum_ub <= {{(SW-DSW){1'b0}}, dist4_q[UB]};
    sep_vb  = rsum_vb <= {{(SW-DSW){1'b0}}, dist4_q[VB]};
  end

  logic v5_q;
  logic overlap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    overlap_q <= !(sep_ua || sep_va || sep_ub || sep_vb);
  end

  assign valid_o   = v5_q;
  assign overlap_o = overlap_q;

endmodule

`default_nettype wire

[design/obb_overlap_test_2d_unit.sv]
// Top level of the 2-D oriented-box overlap unit (separating-axis test).
//
// Usage:
//   Drive both boxes on the *_i ports and raise start for one cycle per item.
//   busy is always low, so an item is taken at every clock edge with start
//   high; a new box pair may follow in every cycle.
//   Each item yields one result: done_o is high for exactly one cycle and
//   overlap_o holds the verdict in that cycle (1 = boxes overlap, 0 = some
//   box axis separates them; touching counts as separated).
//   Throughput is one item per cycle. The five register stages from the
//   accepting edge to the result are: center difference, axis and
//   distance products, dot sums with floor and magnitude, extent
//   products, radius sums and compare.
//   The receiver has no way to stall the unit; results must be taken as they
//   appear.
//   Reset clears all valid bits at once; items in flight are dropped and no
//   result strobe follows them.
`default_nettype none

module obb_overlap_test_2d_unit #(
  parameter int unsigned COORD_WIDTH    = obbot_pkg::COORD_WIDTH_DEF,
  parameter int unsigned AXIS_FRAC_BITS = obbot_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_WIDTH-1:0]    a_center_x_i,
  input  logic signed [COORD_WIDTH-1:0]    a_center_y_i,
  input  logic signed [AXIS_FRAC_BITS+1:0] a_axis_x_i,
  input  logic signed [AXIS_FRAC_BITS+1:0] a_axis_y_i,
  input  logic        [COORD_WIDTH-2:0]    a_half_width_i,
  input  logic        [COORD_WIDTH-2:0]    a_half_height_i,
  input  logic signed [COORD_WIDTH-1:0]    b_center_x_i,
  input  logic signed [COORD_WIDTH-1:0]    b_center_y_i,
  input  logic signed [AXIS_FRAC_BITS+1:0] b_axis_x_i,
  input  logic signed [AXIS_FRAC_BITS+1:0] b_axis_y_i,
  input  logic        [COORD_WIDTH-2:0]    b_half_width_i,
  input  logic        [COORD_WIDTH-2:0]    b_half_height_i,
  output logic                             done_o,
  output logic                             overlap_o
);

  localparam int unsigned AW  = AXIS_FRAC_BITS + 2;
  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned HW  = COORD_WIDTH - 1;
  localparam int unsigned FW  = AXIS_FRAC_BITS + 5;
  localparam int unsigned DSW = COORD_WIDTH + AXIS_FRAC_BITS + 4;

  assign busy = 1'b0;

  // Stage 1: capture item, form center difference
  logic                 v1_q;
  logic signed [AW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [DW-1:0] dx_q, dy_q, dx_d, dy_d;
  logic [HW-1:0]        hwa_q, hha_q, hwb_q, hhb_q;

  assign dx_d = {a_center_x_i[COORD_WIDTH-1], a_center_x_i}
              - {b_center_x_i[COORD_WIDTH-1], b_center_x_i};
  assign dy_d = {a_center_y_i[COORD_WIDTH-1], a_center_y_i}
              - {b_center_y_i[COORD_WIDTH-1], b_center_y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= a_axis_x_i;
    ay_q  <= a_axis_y_i;
    bx_q  <= b_axis_x_i;
    by_q  <= b_axis_y_i;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    hwa_q <= a_half_width_i;
    hha_q <= a_half_height_i;
    hwb_q <= b_half_width_i;
    hhb_q <= b_half_height_i;
  end

  logic           v3;
  logic [FW-1:0]  fna, fnb, fc, fs, fsn;
  logic [DSW-1:0] axis_dist [obbot_pkg::NUM_AXES];
  logic [HW-1:0]  hwa3, hha3, hwb3, hhb3;

  obbot_proj #(
    .COORD_WIDTH   (COORD_WIDTH),
    .AXIS_FRAC_BITS(AXIS_FRAC_BITS)
  ) u_proj (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (v1_q),
    .a_axis_x_i     (ax_q),
    .a_axis_y_i     (ay_q),
    .b_axis_x_i     (bx_q),
    .b_axis_y_i     (by_q),
    .dx_i           (dx_q),
    .dy_i           (dy_q),
    .a_half_width_i (hwa_q),
    .a_half_height_i(hha_q),
    .b_half_width_i (hwb_q),
    .b_half_height_i(hhb_q),
    .valid_o        (v3),
    .fna_o          (fna),
    .fnb_o          (fnb),
    .fc_o           (fc),
    .fs_o           (fs),
    .fsn_o          (fsn),
    .dist_o         (axis_dist),
    .a_half_width_o (hwa3),
    .a_half_height_o(hha3),
    .b_half_width_o (hwb3),
    .b_half_height_o(hhb3)
  );

  obbot_sep #(
    .COORD_WIDTH   (COORD_WIDTH),
    .AXIS_FRAC_BITS(AXIS_FRAC_BITS)
  ) u_sep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (v3),
    .fna_i          (fna),
    .fnb_i          (fnb),
    .fc_i           (fc),
    .fs_i           (fs),
    .fsn_i          (fsn),
    .dist_i         (axis_dist),
    .a_half_width_i (hwa3),
    .a_half_height_i(hha3),
    .b_half_width_i (hwb3),
    .b_half_height_i(hhb3),
    .valid_o        (done_o),
    .overlap_o      (overlap_o)
  );

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(obbot_pkg::LATENCY) done_o)
    else $error("accepted item produced no result strobe");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, obbot_pkg::LATENCY))
    else $error("result strobe without a matching item");

  a_zero_axis_separates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && a_axis_x_i == '0 && a_axis_y_i == '0) |-> ##(obbot_pkg::LATENCY)
      (done_o && !overlap_o))
    else $error("zero axis of box A must report no overlap");
`endif

endmodule

`default_nettype wire
